// ===== hdl/kwnl_pkg.sv =====
// Shared types, constants and character helpers for the keyword, number and identifier lexer.
`timescale 1ns / 1ps

package kwnl_pkg;

  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF = 12;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QUEUE_AW        = $clog2(QUEUE_DEPTH);

  typedef enum logic [3:0] {
    KIND_END      = 4'd0,
    KIND_INT      = 4'd1,
    KIND_IF       = 4'd2,
    KIND_FLOAT    = 4'd3,
    KIND_VAR      = 4'd4,
    KIND_STAR     = 4'd5,
    KIND_SLASH    = 4'd6,
    KIND_MINUS    = 4'd7,
    KIND_PLUS     = 4'd8,
    KIND_EQ       = 4'd9,
    KIND_EQEQ     = 4'd10,
    KIND_INTLIT   = 4'd11,
    KIND_FLOATLIT = 4'd12,
    KIND_IDENT    = 4'd13,
    KIND_UNKNOWN  = 4'd14
  } kind_e;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_EOT   = 8'hFF;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Keyword recogniser progress codes.
  localparam logic [3:0] KW_NONE  = 4'd0;
  localparam logic [3:0] KW_I     = 4'd1;
  localparam logic [3:0] KW_IN    = 4'd2;
  localparam logic [3:0] KW_INT   = 4'd3;
  localparam logic [3:0] KW_IF    = 4'd4;
  localparam logic [3:0] KW_F     = 4'd5;
  localparam logic [3:0] KW_FL    = 4'd6;
  localparam logic [3:0] KW_FLO   = 4'd7;
  localparam logic [3:0] KW_FLOA  = 4'd8;
  localparam logic [3:0] KW_FLOAT = 4'd9;
  localparam logic [3:0] KW_V     = 4'd10;
  localparam logic [3:0] KW_VA    = 4'd11;
  localparam logic [3:0] KW_VAR   = 4'd12;
  localparam logic [3:0] KW_DEAD  = 4'd15;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [3:0] kw_first(input logic [7:0] c);
    logic [3:0] r;
    if (c == "i") r = KW_I;
    else if (c == "f") r = KW_F;
    else if (c == "v") r = KW_V;
    else r = KW_DEAD;
    return r;
  endfunction

  function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
    logic [3:0] r;
    r = KW_DEAD;
    unique case (p)
      KW_I:    r = (c == "n") ? KW_IN : ((c == "f") ? KW_IF : KW_DEAD);
      KW_IN:   r = (c == "t") ? KW_INT : KW_DEAD;
      KW_F:    r = (c == "l") ? KW_FL : KW_DEAD;
      KW_FL:   r = (c == "o") ? KW_FLO : KW_DEAD;
      KW_FLO:  r = (c == "a") ? KW_FLOA : KW_DEAD;
      KW_FLOA: r = (c == "t") ? KW_FLOAT : KW_DEAD;
      KW_V:    r = (c == "a") ? KW_VA : KW_DEAD;
      KW_VA:   r = (c == "r") ? KW_VAR : KW_DEAD;
      default: r = KW_DEAD;
    endcase
    return r;
  endfunction

  function automatic kind_e word_kind(input logic [3:0] p);
    kind_e k;
    unique case (p)
      KW_INT:   k = KIND_INT;
      KW_IF:    k = KIND_IF;
      KW_FLOAT: k = KIND_FLOAT;
      KW_VAR:   k = KIND_VAR;
      default:  k = KIND_IDENT;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/kwnl_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`timescale 1ns / 1ps

interface kwnl_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface kwnl_token_if #(
  parameter int unsigned OFFSET_BITS = kwnl_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = kwnl_pkg::LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  kwnl_pkg::kind_e        token_kind;
  logic [OFFSET_BITS-1:0] token_start;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   last_of_run;

  modport source (output valid, output token_kind, output token_start,
                  output token_length, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input token_start,
                input token_length, input last_of_run, output ready);
endinterface

// ===== hdl/kwnl_front.sv =====
// Scanner front end: accepts one byte per cycle while the token queue has room and forms the tokens that it completes.
`timescale 1ns / 1ps

module kwnl_front #(
  parameter int unsigned OFFSET_BITS = kwnl_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = kwnl_pkg::LENGTH_BITS_DEF,
  parameter type         tok_t       = logic,
  parameter type         rec_t       = logic
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              char_code_i,
  input  kwnl_pkg::queue_status_t q_status_i,
  output logic                    push_o,
  output rec_t                    push_rec_o
);

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT,
    MODE_FRAC,
    MODE_COMMENT,
    MODE_EQ
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [3:0]             kw_q, kw_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0] len_q, len_d, len_grow;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  logic       accept;
  logic       done;
  logic       emit0, emit1;
  tok_t       tok0, tok1;
  logic [7:0] c;

  assign c          = char_code_i;
  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign len_grow   = (len_q == {LENGTH_BITS{1'b1}}) ? len_q : len_q + LENGTH_BITS'(1);

  always_comb begin
    mode_d  = mode_q;
    kw_d    = kw_q;
    start_d = start_q;
    len_d   = len_q;
    pos_d   = pos_q + OFFSET_BITS'(1);
    done    = 1'b0;
    emit0   = 1'b0;
    emit1   = 1'b0;
    tok0    = '{kind: kwnl_pkg::KIND_IDENT, start: start_q, len: len_q};
    tok1    = '{kind: kwnl_pkg::KIND_UNKNOWN, start: pos_q, len: LENGTH_BITS'(1)};

    // Continue or close the pending token.
    unique case (mode_q)
      MODE_IDENT: begin
        if (kwnl_pkg::is_word(c)) begin
          kw_d  = kwnl_pkg::kw_next(kw_q, c);
          len_d = len_grow;
          done  = 1'b1;
        end else begin
          emit0     = 1'b1;
          tok0.kind = kwnl_pkg::word_kind(kw_q);
        end
      end
      MODE_INT: begin
        if (kwnl_pkg::is_digit(c)) begin
          len_d = len_grow;
          done  = 1'b1;
        end else if (c == kwnl_pkg::CH_DOT) begin
          len_d  = len_grow;
          mode_d = MODE_FRAC;
          done   = 1'b1;
        end else begin
          emit0     = 1'b1;
          tok0.kind = kwnl_pkg::KIND_INTLIT;
        end
      end
      MODE_FRAC: begin
        if (kwnl_pkg::is_digit(c)) begin
          len_d = len_grow;
          done  = 1'b1;
        end else begin
          emit0     = 1'b1;
          tok0.kind = kwnl_pkg::KIND_FLOATLIT;
        end
      end
      MODE_EQ: begin
        emit0 = 1'b1;
        if (c == kwnl_pkg::CH_EQ) begin
          tok0.kind = kwnl_pkg::KIND_EQEQ;
          tok0.len  = LENGTH_BITS'(2);
          mode_d    = MODE_IDLE;
          done      = 1'b1;
        end else begin
          tok0.kind = kwnl_pkg::KIND_EQ;
          tok0.len  = LENGTH_BITS'(1);
        end
      end
      default: begin
      end
    endcase

    // Treat the byte on its own.
    if (!done) begin
      if (mode_q != MODE_COMMENT) mode_d = MODE_IDLE;
      if ((c == kwnl_pkg::CH_NUL) || (c == kwnl_pkg::CH_EOT)) begin
        emit1     = 1'b1;
        tok1.kind = kwnl_pkg::KIND_END;
        tok1.len  = '0;
        mode_d    = MODE_IDLE;
        kw_d      = kwnl_pkg::KW_NONE;
        start_d   = '0;
        len_d     = '0;
        pos_d     = '0;
      end else if (mode_q == MODE_COMMENT) begin
        if (c == kwnl_pkg::CH_NL) mode_d = MODE_IDLE;
      end else if ((c == kwnl_pkg::CH_SPACE) || (c == kwnl_pkg::CH_TAB) ||
                   (c == kwnl_pkg::CH_NL)) begin
      end else if (c == kwnl_pkg::CH_HASH) begin
        mode_d = MODE_COMMENT;
      end else if (c == kwnl_pkg::CH_STAR) begin
        emit1     = 1'b1;
        tok1.kind = kwnl_pkg::KIND_STAR;
      end else if (c == kwnl_pkg::CH_SLASH) begin
        emit1     = 1'b1;
        tok1.kind = kwnl_pkg::KIND_SLASH;
      end else if (c == kwnl_pkg::CH_MINUS) begin
        emit1     = 1'b1;
        tok1.kind = kwnl_pkg::KIND_MINUS;
      end else if (c == kwnl_pkg::CH_PLUS) begin
        emit1     = 1'b1;
        tok1.kind = kwnl_pkg::KIND_PLUS;
      end else if (c == kwnl_pkg::CH_EQ) begin
        mode_d  = MODE_EQ;
        start_d = pos_q;
        len_d   = LENGTH_BITS'(1);
      end else if (kwnl_pkg::is_digit(c)) begin
        mode_d  = MODE_INT;
        start_d = pos_q;
        len_d   = LENGTH_BITS'(1);
      end else if (kwnl_pkg::is_alpha(c) || (c == kwnl_pkg::CH_UNDER)) begin
        mode_d  = MODE_IDENT;
        start_d = pos_q;
        len_d   = LENGTH_BITS'(1);
        kw_d    = kwnl_pkg::kw_first(c);
      end else begin
        emit1     = 1'b1;
        tok1.kind = kwnl_pkg::KIND_UNKNOWN;
      end
    end
  end

  always_comb begin
    push_o = accept && (emit0 || emit1);
    if (emit0) begin
      push_rec_o.first  = tok0;
      push_rec_o.second = tok1;
      push_rec_o.two    = emit1;
    end else begin
      push_rec_o.first  = tok1;
      push_rec_o.second = tok1;
      push_rec_o.two    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      kw_q    <= kwnl_pkg::KW_NONE;
      start_q <= '0;
      len_q   <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      kw_q    <= kw_d;
      start_q <= start_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ===== hdl/kwnl_queue.sv =====
// Short queue of token groups between the scanner and the output stage.
`timescale 1ns / 1ps

module kwnl_queue #(
  parameter type rec_t = logic
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  rec_t                    push_rec_i,
  input  logic                    pop_i,
  output rec_t                    head_o,
  output kwnl_pkg::queue_status_t status_o
);

  localparam int unsigned AW = kwnl_pkg::QUEUE_AW;
  localparam int unsigned CW = AW + 1;

  rec_t          mem_q [kwnl_pkg::QUEUE_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign status_o.full      = (cnt_q == CW'(kwnl_pkg::QUEUE_DEPTH));
  assign status_o.not_empty = (cnt_q != '0);
  assign do_push            = push_i && !status_o.full;
  assign do_pop             = pop_i && status_o.not_empty;
  assign head_o             = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == AW'(kwnl_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + AW'(1);
      if (do_pop) rd_q <= (rd_q == AW'(kwnl_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + AW'(1);
      unique case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/kwnl_back.sv =====
// Output stage: sends the tokens of each queued group one word at a time.
`timescale 1ns / 1ps

module kwnl_back #(
  parameter type tok_t = logic,
  parameter type rec_t = logic
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rec_t                    head_i,
  input  kwnl_pkg::queue_status_t q_status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output tok_t                    out_tok_o,
  output logic                    out_last_o
);

  logic valid_q;
  tok_t tok_q;
  logic last_q;
  logic pend_q;
  tok_t pend_tok_q;
  logic slot_free;

  assign slot_free   = !valid_q || out_ready_i;
  assign pop_o       = slot_free && !pend_q && q_status_i.not_empty;
  assign out_valid_o = valid_q;
  assign out_tok_o   = tok_q;
  assign out_last_o  = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pend_q  <= 1'b0;
    end else if (slot_free) begin
      if (pend_q) begin
        valid_q <= 1'b1;
        pend_q  <= 1'b0;
      end else if (q_status_i.not_empty) begin
        valid_q <= 1'b1;
        pend_q  <= head_i.two;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (pend_q) begin
        tok_q  <= pend_tok_q;
        last_q <= 1'b1;
      end else if (q_status_i.not_empty) begin
        tok_q      <= head_i.first;
        last_q     <= !head_i.two;
        pend_tok_q <= head_i.second;
      end
    end
  end

endmodule

// ===== hdl/keyword_number_ident_lexer.sv =====
// Top level of the streaming lexer for keywords, numbers and identifiers.
// Throughput: one source byte per cycle while the token queue has room; a byte that
// completes two tokens occupies the output register with each in turn, absorbed by
// the four-entry token queue. The first token of a byte passes through the queue to
// the output register; a second token from the same byte waits in a pending register.
// Reset (asynchronous, active low) returns the scanner to idle at offset zero and
// empties the queue and output register; no clearing pass is needed.
`timescale 1ns / 1ps

module keyword_number_ident_lexer #(
  parameter int unsigned OFFSET_BITS = kwnl_pkg::OFFSET_BITS_DEF,
  parameter int unsigned LENGTH_BITS = kwnl_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  kwnl_char_if.sink    char_i,
  kwnl_token_if.source token_o
);

  typedef struct packed {
    kwnl_pkg::kind_e        kind;
    logic [OFFSET_BITS-1:0] start;
    logic [LENGTH_BITS-1:0] len;
  } tok_t;

  typedef struct packed {
    logic two;
    tok_t first;
    tok_t second;
  } rec_t;

  kwnl_pkg::queue_status_t q_status;
  logic                    push;
  rec_t                    push_rec;
  logic                    pop;
  rec_t                    head;
  tok_t                    out_tok;

  kwnl_front #(
    .OFFSET_BITS (OFFSET_BITS),
    .LENGTH_BITS (LENGTH_BITS),
    .tok_t       (tok_t),
    .rec_t       (rec_t)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (char_i.valid),
    .in_ready_o  (char_i.ready),
    .char_code_i (char_i.char_code),
    .q_status_i  (q_status),
    .push_o      (push),
    .push_rec_o  (push_rec)
  );

  kwnl_queue #(
    .rec_t (rec_t)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .status_o   (q_status)
  );

  kwnl_back #(
    .tok_t (tok_t),
    .rec_t (rec_t)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (token_o.valid),
    .out_ready_i (token_o.ready),
    .out_tok_o   (out_tok),
    .out_last_o  (token_o.last_of_run)
  );

  assign token_o.token_kind   = out_tok.kind;
  assign token_o.token_start  = out_tok.start;
  assign token_o.token_length = out_tok.len;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the lexer: random and directed source text, token-by-token check.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned OFS_W          = kwnl_pkg::OFFSET_BITS_DEF;
  localparam int unsigned LEN_W          = kwnl_pkg::LENGTH_BITS_DEF;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef enum logic [2:0] {
    LM_IDLE,
    LM_WORD,
    LM_INT,
    LM_FRAC,
    LM_COMMENT,
    LM_EQ
  } lex_mode_e;

  typedef struct {
    kwnl_pkg::kind_e  kind;
    logic [OFS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  kwnl_char_if  char_if ();
  kwnl_token_if token_if ();

  keyword_number_ident_lexer u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .char_i  (char_if),
    .token_o (token_if)
  );

  always #6 clk_i = ~clk_i;

  logic [7:0]  src_bytes[$];
  token_t      token_q[$];
  int unsigned bytes_pushed, bytes_taken, tokens_checked, texts_ended, error_count;
  int unsigned send_idle_pct, recv_idle_pct;
  int unsigned holds_asked, holds_served, hold_left, quiet_cycles;

  lex_mode_e        lx_mode;
  logic [39:0]      word_buf;
  int unsigned      word_cnt;
  logic [OFS_W-1:0] tok_start, byte_pos;
  logic [LEN_W-1:0] run_len;
  token_t           step_tok[2];
  int unsigned      step_n;

  function automatic logic digit_p(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic letter_p(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic word_p(input logic [7:0] c);
    return letter_p(c) || digit_p(c) || c == kwnl_pkg::CH_UNDER;
  endfunction

  function automatic kwnl_pkg::kind_e word_token();
    if (word_cnt == 3 && word_buf[23:0] == "int") return kwnl_pkg::KIND_INT;
    if (word_cnt == 2 && word_buf[15:0] == "if") return kwnl_pkg::KIND_IF;
    if (word_cnt == 5 && word_buf == "float") return kwnl_pkg::KIND_FLOAT;
    if (word_cnt == 3 && word_buf[23:0] == "var") return kwnl_pkg::KIND_VAR;
    return kwnl_pkg::KIND_IDENT;
  endfunction

  task automatic lexer_clear();
    lx_mode   = LM_IDLE;
    word_buf  = '0;
    word_cnt  = 0;
    tok_start = '0;
    run_len   = '0;
    byte_pos  = '0;
  endtask

  task automatic note_token(input kwnl_pkg::kind_e k, input logic [OFS_W-1:0] s,
                            input logic [LEN_W-1:0] l);
    step_tok[step_n] = '{k, s, l, 1'b0};
    step_n++;
  endtask

  task automatic open_token(input lex_mode_e m);
    lx_mode   = m;
    tok_start = byte_pos;
    run_len   = LEN_W'(1);
  endtask

  task automatic stretch();
    if (run_len != '1) run_len++;
  endtask

  // Works out the tokens that one source byte completes and queues them in order.
  task automatic lex_byte(input logic [7:0] c);
    logic [OFS_W-1:0] here;
    logic             consumed;
    logic             text_end;
    token_t           t;
    here     = byte_pos;
    consumed = 1'b0;
    text_end = 1'b0;
    step_n   = 0;
    case (lx_mode)
      LM_WORD: begin
        if (word_p(c)) begin
          word_buf = {word_buf[31:0], c};
          if (word_cnt < 6) word_cnt++;
          stretch();
          consumed = 1'b1;
        end else begin
          note_token(word_token(), tok_start, run_len);
        end
      end
      LM_INT: begin
        if (digit_p(c)) begin
          stretch();
          consumed = 1'b1;
        end else if (c == kwnl_pkg::CH_DOT) begin
          stretch();
          lx_mode  = LM_FRAC;
          consumed = 1'b1;
        end else begin
          note_token(kwnl_pkg::KIND_INTLIT, tok_start, run_len);
        end
      end
      LM_FRAC: begin
        if (digit_p(c)) begin
          stretch();
          consumed = 1'b1;
        end else begin
          note_token(kwnl_pkg::KIND_FLOATLIT, tok_start, run_len);
        end
      end
      LM_EQ: begin
        if (c == kwnl_pkg::CH_EQ) begin
          note_token(kwnl_pkg::KIND_EQEQ, tok_start, LEN_W'(2));
          lx_mode  = LM_IDLE;
          consumed = 1'b1;
        end else begin
          note_token(kwnl_pkg::KIND_EQ, tok_start, LEN_W'(1));
        end
      end
      default: begin
      end
    endcase
    if (!consumed) begin
      if (lx_mode != LM_COMMENT) lx_mode = LM_IDLE;
      if (c == kwnl_pkg::CH_NUL || c == kwnl_pkg::CH_EOT) begin
        note_token(kwnl_pkg::KIND_END, here, '0);
        text_end = 1'b1;
      end else if (lx_mode == LM_COMMENT) begin
        if (c == kwnl_pkg::CH_NL) lx_mode = LM_IDLE;
      end else if (c == kwnl_pkg::CH_SPACE || c == kwnl_pkg::CH_TAB ||
                   c == kwnl_pkg::CH_NL) begin
      end else if (c == kwnl_pkg::CH_HASH) begin
        lx_mode = LM_COMMENT;
      end else if (c == kwnl_pkg::CH_STAR) begin
        note_token(kwnl_pkg::KIND_STAR, here, LEN_W'(1));
      end else if (c == kwnl_pkg::CH_SLASH) begin
        note_token(kwnl_pkg::KIND_SLASH, here, LEN_W'(1));
      end else if (c == kwnl_pkg::CH_MINUS) begin
        note_token(kwnl_pkg::KIND_MINUS, here, LEN_W'(1));
      end else if (c == kwnl_pkg::CH_PLUS) begin
        note_token(kwnl_pkg::KIND_PLUS, here, LEN_W'(1));
      end else if (c == kwnl_pkg::CH_EQ) begin
        open_token(LM_EQ);
      end else if (digit_p(c)) begin
        open_token(LM_INT);
      end else if (letter_p(c) || c == kwnl_pkg::CH_UNDER) begin
        open_token(LM_WORD);
        word_buf = {32'd0, c};
        word_cnt = 1;
      end else begin
        note_token(kwnl_pkg::KIND_UNKNOWN, here, LEN_W'(1));
      end
    end
    if (text_end) begin
      lexer_clear();
      texts_ended++;
    end else begin
      byte_pos = byte_pos + OFS_W'(1);
    end
    for (int unsigned i = 0; i < step_n; i++) begin
      t      = step_tok[i];
      t.last = (i == step_n - 1);
      token_q.push_back(t);
    end
  endtask

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_if.valid     <= 1'b0;
      char_if.char_code <= '0;
    end else if (!char_if.valid || char_if.ready) begin
      if (char_if.valid) begin
        lex_byte(char_if.char_code);
        bytes_taken++;
      end
      if (src_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        char_if.valid     <= 1'b1;
        char_if.char_code <= src_bytes.pop_front();
      end else begin
        char_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    token_t want;
    if (!rst_ni) begin
      token_if.ready <= 1'b0;
    end else begin
      if (token_if.valid && token_if.ready) begin
        tokens_checked++;
        if (token_q.size() == 0) begin
          flag_error($sformatf("testbench: unexpected token kind %0d start %0d length %0d last %0b",
                               token_if.token_kind, token_if.token_start,
                               token_if.token_length, token_if.last_of_run));
        end else begin
          want = token_q.pop_front();
          if (token_if.token_kind !== want.kind || token_if.token_start !== want.start ||
              token_if.token_length !== want.len || token_if.last_of_run !== want.last) begin
            flag_error($sformatf({"testbench: token %0d mismatch: expected kind %0d start %0d",
                                  " length %0d last %0b, got kind %0d start %0d length %0d",
                                  " last %0b"},
                                 tokens_checked, want.kind, want.start, want.len, want.last,
                                 token_if.token_kind, token_if.token_start,
                                 token_if.token_length, token_if.last_of_run));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        token_if.ready <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        token_if.ready <= 1'b0;
      end else begin
        token_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((char_if.valid && char_if.ready) || (token_if.valid && token_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
          $display("testbench: done, errors");
          $finish;
        end
      end
    end
  end

  function automatic logic [7:0] rand_word_char();
    int unsigned k;
    k = $urandom_range(0, 62);
    if (k < 26) return 8'(8'h61 + k);
    if (k < 52) return 8'(8'h41 + k - 26);
    if (k < 62) return 8'(8'h30 + k - 52);
    return kwnl_pkg::CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] comment_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 254)); while (c == kwnl_pkg::CH_NL);
    return c;
  endfunction

  task automatic push_byte(input logic [7:0] c);
    src_bytes.push_back(c);
    bytes_pushed++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_lexeme();
    int unsigned pick;
    string       kw;
    string       punct;
    pick  = $urandom_range(0, 99);
    punct = "!$%&()',:;<>?@[]^`{|}~\\\"";
    case ($urandom_range(0, 3))
      0: kw = "int";
      1: kw = "if";
      2: kw = "float";
      default: kw = "var";
    endcase
    if (pick < 12) begin
      push_text(kw);
    end else if (pick < 18) begin
      push_text(kw.substr(0, $urandom_range(1, kw.len()) - 1));
      repeat ($urandom_range(0, 2)) push_byte(rand_word_char());
    end else if (pick < 26) begin
      do push_byte(rand_word_char()); while (digit_p(src_bytes[$]) && src_bytes.size() != 0 &&
                                            $urandom_range(0, 1) == 0);
      repeat ($urandom_range(0, 7)) push_byte(rand_word_char());
    end else if (pick < 36) begin
      repeat ($urandom_range(1, 6)) push_byte(rand_digit());
    end else if (pick < 44) begin
      repeat ($urandom_range(1, 3)) push_byte(rand_digit());
      push_byte(kwnl_pkg::CH_DOT);
      repeat ($urandom_range(0, 3)) push_byte(rand_digit());
    end else if (pick < 60) begin
      case ($urandom_range(0, 5))
        0: push_byte(kwnl_pkg::CH_STAR);
        1: push_byte(kwnl_pkg::CH_SLASH);
        2: push_byte(kwnl_pkg::CH_MINUS);
        3: push_byte(kwnl_pkg::CH_PLUS);
        4: push_byte(kwnl_pkg::CH_EQ);
        default: push_text("==");
      endcase
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 2))
          0: push_byte(kwnl_pkg::CH_SPACE);
          1: push_byte(kwnl_pkg::CH_TAB);
          default: push_byte(kwnl_pkg::CH_NL);
        endcase
      end
    end else if (pick < 76) begin
      push_byte(kwnl_pkg::CH_HASH);
      repeat ($urandom_range(0, 8)) push_byte(comment_char());
      if ($urandom_range(0, 9) != 0) push_byte(kwnl_pkg::CH_NL);
    end else if (pick < 86) begin
      case ($urandom_range(0, 3))
        0: push_byte(kwnl_pkg::CH_DOT);
        1: push_byte(8'($urandom_range(8'h80, 8'hFE)));
        2: push_byte(punct[$urandom_range(0, punct.len() - 1)]);
        default: push_byte(8'($urandom_range(1, 8)));
      endcase
    end else if (pick < 97) begin
      push_byte(8'($urandom_range(0, 255)));
    end else begin
      push_byte($urandom_range(0, 1) ? kwnl_pkg::CH_EOT : kwnl_pkg::CH_NUL);
    end
  endtask

  task automatic push_random(input int unsigned count);
    int unsigned first;
    first = bytes_pushed;
    while (bytes_pushed - first < count) push_lexeme();
  endtask

  task automatic wait_quiet();
    while (bytes_taken != bytes_pushed) @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni            = 1'b0;
    char_if.valid     = 1'b0;
    char_if.char_code = '0;
    token_if.ready    = 1'b0;
    send_idle_pct     = 18;
    recv_idle_pct     = 77;
    lexer_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_text("int=if==float*var/1.2.-3.+ \t#a\n#");
    push_byte(kwnl_pkg::CH_EOT);
    push_byte(8'h80);
    push_text("v");
    push_byte(kwnl_pkg::CH_NUL);
    wait_quiet();

    holds_asked++;
    repeat (24) push_byte(kwnl_pkg::CH_STAR);
    push_random(300);
    wait_quiet();

    send_idle_pct = 77;
    recv_idle_pct = 18;
    push_random(300);
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(280);
    push_byte(kwnl_pkg::CH_NUL);
    wait_quiet();

    $display("testbench: %0d bytes over %0d texts gave %0d tokens, %0d of them wrong",
             bytes_taken, texts_ended, tokens_checked, error_count);
    $display("testbench: keywords, literals, operators, comments and text ends %s",
             "run under three stall patterns and one long output hold-off");
    if (error_count == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
